### src/slfp_pkg.sv
package slfp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned POS_W       = 17;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_ADDR_W  = 3;

   localparam logic [BYTE_W-1:0] SYNC_ONE       = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_TWO       = 8'h62;
   localparam logic [POS_W-1:0]  FRAME_OVERHEAD = 17'd8;
   localparam logic [POS_W-1:0]  MAX_FRAME_LEN_RESET = 17'd512;

   // register index, taken from the word address bit of paddr
   localparam logic REG_MAX_FRAME_LEN = 1'b0;

   typedef enum logic [8:0] {
      PH_SYNC1   = 9'b000000001,
      PH_SYNC2   = 9'b000000010,
      PH_CLASS   = 9'b000000100,
      PH_ID      = 9'b000001000,
      PH_LEN_LO  = 9'b000010000,
      PH_LEN_HI  = 9'b000100000,
      PH_PAYLOAD = 9'b001000000,
      PH_CHECK1  = 9'b010000000,
      PH_CHECK2  = 9'b100000000
   } slfp_phase_type;

   typedef struct packed {
      logic              stored;
      logic [POS_W-1:0]  store_index;
      logic [BYTE_W-1:0] stored_byte;
      logic              frame_end;
      logic              frame_ok;
   } slfp_result_type;

endpackage

### src/slfp_csr.sv
module slfp_csr
   import slfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [POS_W-1:0]      max_frame_len
);

   logic [POS_W-1:0] max_frame_len_ff;
   logic [POS_W-1:0] max_frame_len_in;
   logic             hit;

   assign csr_pready = 1'b1;
   assign hit        = (csr_paddr[2] == REG_MAX_FRAME_LEN);

   always_comb begin
      max_frame_len_in = max_frame_len_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         max_frame_len_in = csr_pwdata[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= MAX_FRAME_LEN_RESET;
      end else begin
         max_frame_len_ff <= max_frame_len_in;
      end
   end

   assign csr_prdata    = hit ? {{(CSR_DATA_W-POS_W){1'b0}}, max_frame_len_ff}
                              : '0;
   assign max_frame_len = max_frame_len_ff;

endmodule

### src/slfp_parser.sv
module slfp_parser
   import slfp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [POS_W-1:0]  max_frame_len,
   output slfp_result_type   result
);

   slfp_phase_type    phase_ff, phase_in;
   logic [POS_W-1:0]  wpos_ff, wpos_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [BYTE_W-1:0] sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0] sum_b_ff, sum_b_in;
   logic [BYTE_W-1:0] check1_ff, check1_in;

   logic [BYTE_W-1:0] acc_a;
   logic [BYTE_W-1:0] acc_b;
   logic [LEN_W-1:0]  len_full;
   logic [LEN_W-1:0]  left_dec;
   logic [POS_W-1:0]  idx;
   logic              stored;
   logic              frame_end;
   logic              frame_ok;

   // running Fletcher sums with this byte added
   assign acc_a    = sum_a_ff + rx_byte;
   assign acc_b    = sum_b_ff + acc_a;
   assign len_full = {rx_byte, left_ff[BYTE_W-1:0]};
   assign left_dec = left_ff - 16'd1;

   always_comb begin
      phase_in  = phase_ff;
      wpos_in   = wpos_ff;
      left_in   = left_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      check1_in = check1_ff;
      stored    = 1'b0;
      frame_end = 1'b0;
      frame_ok  = 1'b0;
      idx       = wpos_ff;

      if (wpos_ff >= max_frame_len) begin
         // buffer full: drop the byte and restart
         wpos_in  = '0;
         phase_in = PH_SYNC1;
      end else begin
         case (phase_ff)
            PH_SYNC1: begin
               if (rx_byte == SYNC_ONE) begin
                  idx      = '0;
                  stored   = 1'b1;
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (rx_byte == SYNC_TWO) begin
                  stored   = 1'b1;
                  phase_in = PH_CLASS;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_CLASS: begin
               stored   = 1'b1;
               sum_a_in = rx_byte;
               sum_b_in = rx_byte;
               phase_in = PH_ID;
            end
            PH_ID: begin
               stored   = 1'b1;
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               stored   = 1'b1;
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               left_in  = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               stored   = 1'b1;
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               left_in  = len_full;
               if (({1'b0, len_full} + FRAME_OVERHEAD) <= max_frame_len) begin
                  phase_in = (len_full == '0) ? PH_CHECK1 : PH_PAYLOAD;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_PAYLOAD: begin
               stored   = 1'b1;
               sum_a_in = acc_a;
               sum_b_in = acc_b;
               left_in  = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_CHECK1;
               end
            end
            PH_CHECK1: begin
               stored    = 1'b1;
               check1_in = rx_byte;
               phase_in  = PH_CHECK2;
            end
            PH_CHECK2: begin
               stored    = 1'b1;
               frame_end = 1'b1;
               frame_ok  = (check1_ff == sum_a_ff) && (rx_byte == sum_b_ff);
               phase_in  = PH_SYNC1;
            end
            default: begin
               phase_in = PH_SYNC1;
            end
         endcase

         if (stored) begin
            wpos_in = idx + 17'd1;
         end
         // length too big: abort the frame
         if (phase_in == PH_SYNC1 && stored && !frame_end) begin
            wpos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         wpos_ff   <= '0;
         left_ff   <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         check1_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         wpos_ff   <= wpos_in;
         left_ff   <= left_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         check1_ff <= check1_in;
      end
   end

   assign result.stored      = stored;
   assign result.store_index = stored ? idx : '0;
   assign result.stored_byte = stored ? rx_byte : '0;
   assign result.frame_end   = frame_end;
   assign result.frame_ok    = frame_ok;

endmodule

### src/sync_length_frame_parser_top.sv
// Sync/length frame parser with running 8-bit Fletcher checksum.
//
// Request channel (req_*): one received byte per request. Response channel
// (rsp_*): exactly one response per request, in order, telling whether the
// byte went into the frame buffer, at which position, and whether it closed
// a frame with a matching checksum. The buffer itself lives with the consumer.
//
// Pipeline: a request accepted into the input register passes on to the
// result register and shows at rsp_valid (two register stages: input, result).
// Throughput: one request per cycle while rsp_ready is high; the only loop
// is the parse state, which is updated by one short step per byte.
//
// Stall: when rsp_ready is low the result register holds, the input register
// takes one more request, then req_ready drops until the response drains.
//
// Reset (synchronous, active high) empties both stages, returns the parser to
// hunting for the first sync byte and loads max_frame_len with 512.
// Write max_frame_len over the csr_* port only while no request is in flight.
module sync_length_frame_parser_top
   import slfp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_rx_byte,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_stored,
   output logic [POS_W-1:0]      rsp_store_index,
   output logic [BYTE_W-1:0]     rsp_stored_byte,
   output logic                  rsp_frame_end,
   output logic                  rsp_frame_ok,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   slfp_result_type   result_ff, result_in;
   slfp_result_type   step_result;
   logic [POS_W-1:0]  max_frame_len;
   logic              advance;
   logic              req_fire;

   // move the held request into the result register when that slot frees up
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   slfp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .max_frame_len (max_frame_len)
   );

   // parse state advances only when a request leaves the input register
   slfp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .rx_byte       (in_byte_ff),
      .max_frame_len (max_frame_len),
      .result        (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;

      // input stage: drop the request once parsed, take a new one if offered
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end

      // result stage: hold while stalled, load on advance
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         result_in    = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      result_ff  <= result_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stored      = result_ff.stored;
   assign rsp_store_index = result_ff.store_index;
   assign rsp_stored_byte = result_ff.stored_byte;
   assign rsp_frame_end   = result_ff.frame_end;
   assign rsp_frame_ok    = result_ff.frame_ok;

endmodule

### src/slfp_checker.sv
module slfp_checker
   import slfp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_stored,
   input logic [POS_W-1:0]  rsp_store_index,
   input logic [BYTE_W-1:0] rsp_stored_byte,
   input logic              rsp_frame_end,
   input logic              rsp_frame_ok
);

   // a good checksum only ever comes with the end of a frame
   ok_needs_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> rsp_frame_end)
      else $error("frame_ok without frame_end");

   // the closing check byte is always stored
   end_needs_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_stored)
      else $error("frame_end on a dropped byte");

   // dropped bytes report zero position and value
   drop_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stored |-> (rsp_store_index == '0) && (rsp_stored_byte == '0))
      else $error("nonzero fields on a dropped byte");

   // reset empties the result stage
   reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // stalled response holds
   stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_store_index)
         && $stable(rsp_stored_byte) && $stable(rsp_frame_ok))
      else $error("response changed while stalled");

endmodule

bind sync_length_frame_parser_top slfp_checker u_slfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_stored      (rsp_stored),
   .rsp_store_index (rsp_store_index),
   .rsp_stored_byte (rsp_stored_byte),
   .rsp_frame_end   (rsp_frame_end),
   .rsp_frame_ok    (rsp_frame_ok)
);

### sim/tb_sync_length_frame_parser_top.sv
module tb_sync_length_frame_parser_top
   import slfp_pkg::*;
();

   // Byte address of max_frame_len on the register port.
   localparam logic [CSR_ADDR_W-1:0] MAX_LEN_ADDR = CSR_ADDR_W'(4 * REG_MAX_FRAME_LEN);

   // How a generated frame is spoiled on purpose.
   typedef enum int {
      FLAW_NONE,
      FLAW_CHECK_A,
      FLAW_CHECK_B
   } frame_flaw_type;

   // Frame tracker: mirrors the parser state, predicts one response per
   // received byte and holds the predictions until the responses come back.
   class frame_scoreboard;
      logic [POS_W-1:0]    limit_len;
      slfp_phase_type      phase;
      logic [POS_W-1:0]    write_at;
      logic [LEN_W-1:0]    payload_rest;
      logic [BYTE_W-1:0]   run_a;
      logic [BYTE_W-1:0]   run_b;
      logic [BYTE_W-1:0]   check_a_seen;
      slfp_result_type     expected_q[$];
      int unsigned         errors;

      function new();
         limit_len    = MAX_FRAME_LEN_RESET;
         phase        = PH_SYNC1;
         write_at     = '0;
         payload_rest = '0;
         run_a        = '0;
         run_b        = '0;
         check_a_seen = '0;
         errors       = 0;
      endfunction

      function void set_max_len(logic [POS_W-1:0] value);
         limit_len = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void accumulate(logic [BYTE_W-1:0] value);
         run_a = run_a + value;
         run_b = run_b + run_a;
      endfunction

      // Advance the parser mirror by one byte and queue its response.
      function void note_request(logic [BYTE_W-1:0] value);
         slfp_result_type  want;
         logic             keep;
         logic             last;
         logic             good;
         logic [POS_W-1:0] idx;
         keep = 1'b0;
         last = 1'b0;
         good = 1'b0;
         idx  = '0;
         if (write_at >= limit_len) begin
            // buffer full: drop the byte and hunt for sync again
            write_at = '0;
            phase    = PH_SYNC1;
         end else begin
            case (phase)
               PH_SYNC1: begin
                  if (value == SYNC_ONE) begin
                     write_at = '0;
                     keep     = 1'b1;
                     phase    = PH_SYNC2;
                  end
               end
               PH_SYNC2: begin
                  if (value == SYNC_TWO) begin
                     keep  = 1'b1;
                     phase = PH_CLASS;
                  end else begin
                     phase = PH_SYNC1;
                  end
               end
               PH_CLASS: begin
                  keep  = 1'b1;
                  run_a = '0;
                  run_b = '0;
                  accumulate(value);
                  phase = PH_ID;
               end
               PH_ID: begin
                  keep = 1'b1;
                  accumulate(value);
                  phase = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  keep = 1'b1;
                  accumulate(value);
                  payload_rest = {8'h00, value};
                  phase = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  keep = 1'b1;
                  accumulate(value);
                  payload_rest[15:8] = value;
                  if ({1'b0, payload_rest} + FRAME_OVERHEAD <= limit_len) begin
                     phase = (payload_rest == '0) ? PH_CHECK1 : PH_PAYLOAD;
                  end else begin
                     phase = PH_SYNC1;
                  end
               end
               PH_PAYLOAD: begin
                  keep = 1'b1;
                  accumulate(value);
                  payload_rest = payload_rest - 16'd1;
                  if (payload_rest == '0) begin
                     phase = PH_CHECK1;
                  end
               end
               PH_CHECK1: begin
                  keep         = 1'b1;
                  check_a_seen = value;
                  phase        = PH_CHECK2;
               end
               PH_CHECK2: begin
                  keep  = 1'b1;
                  last  = 1'b1;
                  good  = (check_a_seen == run_a) && (value == run_b);
                  phase = PH_SYNC1;
               end
               default: begin
                  phase = PH_SYNC1;
               end
            endcase
            if (keep) begin
               idx      = write_at;
               write_at = write_at + 17'd1;
            end
            // length too big: the frame is abandoned after its length byte
            if (phase == PH_SYNC1 && keep && !last) begin
               write_at = '0;
            end
         end
         want.stored      = keep;
         want.store_index = keep ? idx : '0;
         want.stored_byte = keep ? value : '0;
         want.frame_end   = last;
         want.frame_ok    = good;
         expected_q.push_back(want);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      // Match one response against the oldest prediction.
      function void check_response(slfp_result_type got);
         slfp_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("stored", 32'(want.stored), 32'(got.stored));
         compare_field("store_index", 32'(want.store_index), 32'(got.store_index));
         compare_field("stored_byte", 32'(want.stored_byte), 32'(got.stored_byte));
         compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
         compare_field("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_stored;
   logic [POS_W-1:0]      rsp_store_index;
   logic [BYTE_W-1:0]     rsp_stored_byte;
   logic                  rsp_frame_end;
   logic                  rsp_frame_ok;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_scoreboard frames;
   int unsigned     sent_bytes      = 0;
   int unsigned     cur_max_len     = 32'(MAX_FRAME_LEN_RESET);
   int unsigned     csr_errors      = 0;
   int unsigned     hold_off_cycles = 0;
   bit              gaps_on         = 1'b0;
   bit              idle_allowed    = 1'b0;

   sync_length_frame_parser_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_stored      (rsp_stored),
      .rsp_store_index (rsp_store_index),
      .rsp_stored_byte (rsp_stored_byte),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_ok    (rsp_frame_ok),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Offer one byte from a falling edge, hold it until accepted, then
   // return on the next falling edge with valid still high.
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_rx_byte = value;
      do @(posedge clock); while (!req_ready);
      frames.note_request(value);
      sent_bytes++;
      @(negedge clock);
   endtask

   // Send sync, class, id and length; hand back the running check sums.
   task automatic send_header(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
                              input logic [LEN_W-1:0] len,
                              output logic [BYTE_W-1:0] sum_a, output logic [BYTE_W-1:0] sum_b);
      logic [BYTE_W-1:0] fields[4];
      fields = '{cls, id, len[7:0], len[15:8]};
      sum_a  = '0;
      sum_b  = '0;
      send_byte(SYNC_ONE);
      send_byte(SYNC_TWO);
      foreach (fields[k]) begin
         sum_a = sum_a + fields[k];
         sum_b = sum_b + sum_a;
         send_byte(fields[k]);
      end
   endtask

   // Send a complete frame with random payload; spoil one check byte if asked.
   task automatic send_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] id,
                             input logic [LEN_W-1:0] len, input frame_flaw_type flaw);
      logic [BYTE_W-1:0] sum_a;
      logic [BYTE_W-1:0] sum_b;
      logic [BYTE_W-1:0] value;
      send_header(cls, id, len, sum_a, sum_b);
      repeat (len) begin
         value = 8'($urandom_range(0, 255));
         sum_a = sum_a + value;
         sum_b = sum_b + sum_a;
         send_byte(value);
      end
      if (flaw == FLAW_CHECK_A) sum_a = sum_a ^ 8'($urandom_range(1, 255));
      if (flaw == FLAW_CHECK_B) sum_b = sum_b ^ 8'($urandom_range(1, 255));
      send_byte(sum_a);
      send_byte(sum_b);
   endtask

   // Mostly well-formed frames sized to fit the current limit, plus broken
   // frames and line noise, until n_bytes more bytes have gone in.
   task automatic random_traffic(input int unsigned n_bytes);
      int unsigned       stop_at;
      int unsigned       pick;
      int unsigned       room;
      int                too_big;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] sum_a;
      logic [BYTE_W-1:0] sum_b;
      stop_at = sent_bytes + n_bytes;
      while (sent_bytes < stop_at) begin
         if (idle_allowed) gaps_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         room = (cur_max_len >= 8) ? cur_max_len - 8 : 0;
         len  = (room > 24) ? LEN_W'($urandom_range(0, 24)) : LEN_W'($urandom_range(0, room));
         if (pick < 4 && room > 24) begin
            len = LEN_W'($urandom_range(25, (room > 160) ? 160 : room));
         end
         if (pick < 65) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       FLAW_NONE);
         end else if (pick < 77) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                       pick[0] ? FLAW_CHECK_A : FLAW_CHECK_B);
         end else if (pick < 83) begin
            // bad second sync byte
            value = 8'($urandom_range(0, 255));
            if (value == SYNC_TWO) value = 8'h00;
            send_byte(SYNC_ONE);
            send_byte(value);
         end else if (pick < 89) begin
            // length field one past what fits, or the largest length
            too_big = int'(cur_max_len) - 7;
            if (too_big < 0) len = LEN_W'($urandom_range(0, 65535));
            else if (too_big > 65535 || $urandom_range(0, 1) == 0) len = 16'hFFFF;
            else len = LEN_W'(too_big);
            send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len,
                        sum_a, sum_b);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               value = ($urandom_range(0, 3) == 0) ? SYNC_ONE : 8'($urandom_range(0, 255));
               send_byte(value);
            end
         end
      end
   endtask

   // Hold the sender until every predicted response has been taken, then
   // let the pipeline settle.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (frames.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write max_frame_len with the block idle, then read it back.
   task automatic set_max_len(input logic [POS_W-1:0] value);
      wait_drained();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = MAX_LEN_ADDR;
      csr_pwdata  = CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      frames.set_max_len(value);
      cur_max_len = 32'(value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[POS_W-1:0] !== value) begin
         $error("max_frame_len readback: expected %0d, got %0d", value,
                csr_prdata[POS_W-1:0]);
         csr_errors++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // Response sink: random short stalls, plus a long hold-off on request
   // from the stimulus so the block fills up and backs up its input.
   initial begin : response_sink
      int unsigned stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8);
         end else begin
            stall = 0;
         end
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // Check every response taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         frames.check_response(slfp_result_type'({rsp_stored, rsp_store_index,
                                                  rsp_stored_byte, rsp_frame_end,
                                                  rsp_frame_ok}));
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] sum_a;
      logic [BYTE_W-1:0] sum_b;
      frames      = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed pass at the reset limit of 512: noise at both byte
      // extremes, an empty frame, a bad second sync, a length that cannot
      // fit, and a one-byte frame with a wrong second check byte.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h01, 8'h02, 16'd0, FLAW_NONE);
      send_byte(SYNC_ONE);
      send_byte(8'h13);
      send_header(8'hFF, 8'h00, 16'hFFFF, sum_a, sum_b);
      send_frame(8'hAA, 8'h55, 16'd1, FLAW_CHECK_B);

      // Random traffic with idling on both sides; partway through, stall the
      // sink for a long stretch while bytes keep coming, then pause the
      // sender until everything has drained.
      idle_allowed = 1'b1;
      random_traffic(90);
      hold_off_cycles = 60;
      random_traffic(90);
      wait_drained();

      // Limit 0: nothing is ever stored.
      set_max_len(17'd0);
      random_traffic(40);

      // Limit 8: only empty frames fit, and the byte after each is dropped.
      set_max_len(17'd8);
      random_traffic(80);

      // Limit 12: a 4-byte payload fills the buffer exactly, 5 is too long.
      set_max_len(17'd12);
      send_frame(8'h10, 8'h20, 16'd4, FLAW_NONE);
      send_frame(8'h10, 8'h20, 16'd5, FLAW_NONE);
      random_traffic(50);

      // Limit 4: the buffer fills up inside the header.
      set_max_len(17'd4);
      random_traffic(40);

      // One below the top: the largest length field is just too long.
      set_max_len(17'd65542);
      send_header(8'h7F, 8'h80, 16'hFFFF, sum_a, sum_b);

      // Top of the range, with one long frame.
      set_max_len(17'd65543);
      send_frame(8'h0F, 8'hF0, 16'd300, FLAW_NONE);
      random_traffic(40);

      // A random small limit, with another long hold-off.
      set_max_len(POS_W'($urandom_range(9, 48)));
      random_traffic(50);
      hold_off_cycles = 45;
      random_traffic(50);

      // Last stretch back at 512 with no idling on either side.
      set_max_len(17'd512);
      idle_allowed = 1'b0;
      gaps_on      = 1'b0;
      random_traffic(100);

      wait_drained();
      if (frames.errors == 0 && csr_errors == 0 && frames.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #8000000;
      $display("simulation failed");
      $finish;
   end

endmodule
